[rtl/core/assert_macros.svh]
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/core/avimux_pkg.sv]
`default_nettype none

package avimux_pkg;

    localparam int HEADER_WORDS = 56;
    localparam int FRAME_WORDS  = 6;
    localparam int CLOSE_PRE    = 2;
    localparam int CFG_INDEX_W  = 8;

    // item kinds
    localparam logic [1:0] ACT_OPEN  = 2'd0;
    localparam logic [1:0] ACT_FRAME = 2'd1;
    localparam logic [1:0] ACT_CLOSE = 2'd2;

    // result destinations
    localparam logic [1:0] DEST_MOVI   = 2'd0;
    localparam logic [1:0] DEST_INDEX  = 2'd1;
    localparam logic [1:0] DEST_HEADER = 2'd2;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_WIDTH  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT = 8'd1;

    // fourcc words, first character in the low byte
    localparam logic [31:0] FCC_RIFF = 32'h4646_4952;
    localparam logic [31:0] FCC_AVI  = 32'h2049_5641;
    localparam logic [31:0] FCC_LIST = 32'h5453_494C;
    localparam logic [31:0] FCC_HDRL = 32'h6C72_6468;
    localparam logic [31:0] FCC_AVIH = 32'h6869_7661;
    localparam logic [31:0] FCC_STRL = 32'h6C72_7473;
    localparam logic [31:0] FCC_STRH = 32'h6872_7473;
    localparam logic [31:0] FCC_VIDS = 32'h7364_6976;
    localparam logic [31:0] FCC_MJPG = 32'h4750_4A4D;
    localparam logic [31:0] FCC_STRF = 32'h6672_7473;
    localparam logic [31:0] FCC_MOVI = 32'h6976_6F6D;
    localparam logic [31:0] FCC_00DC = 32'h6364_3030;
    localparam logic [31:0] FCC_IDX1 = 32'h3178_6469;

    localparam logic [31:0] DEFAULT_USF  = 32'd100000;
    localparam logic [31:0] DEFAULT_RATE = 32'd10000;
    localparam logic [31:0] PLANES_BITS  = 32'h0018_0001;

endpackage

`default_nettype wire

[rtl/core/avi_mjpeg_chunk_muxer.sv]
// Framing-word generator for a single-stream MJPEG AVI file. Each open, frame
// or close beat (tuser = action) yields a run of 32-bit words on the output
// stream, tlast on the final one. An open beat clears the frame count, byte
// total and largest frame and gives the 56 header words. A frame beat gives
// six words (chunk header and idx1 entry). A close beat runs three 42-bit
// divisions on one shared restoring divider, one quotient bit per cycle, then
// gives 58 words. The input is not ready while a beat is being worked on;
// output stalls only hold the sequencer.
`default_nettype none

module avi_mjpeg_chunk_muxer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [avimux_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // frame_len[23:0], duration_ms[55:24]
    input  logic [1:0]  s_axis_tuser,  // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // word_offset[5:0], word[37:6], pad_after[38]
    output logic [1:0]  m_axis_tuser,  // dest
    output logic        m_axis_tlast
);
    import avimux_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PREP = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    localparam logic [1:0] DIV_USF   = 2'd0;
    localparam logic [1:0] DIV_RATE  = 2'd1;
    localparam logic [1:0] DIV_BRATE = 2'd2;

    localparam int DVD_W = 42;
    localparam int CNT_W = $clog2(DVD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);
    localparam logic [DVD_W-1:0] RATE_DVD = DVD_W'(1000000000);

    localparam logic [5:0] LAST_OPEN  = 6'(HEADER_WORDS - 1);
    localparam logic [5:0] LAST_FRAME = 6'(FRAME_WORDS - 1);
    localparam logic [5:0] LAST_CLOSE = 6'(HEADER_WORDS + CLOSE_PRE - 1);

    logic [1:0]  r_state;
    logic [1:0]  r_act;
    logic [23:0] r_len;
    logic [31:0] r_dur;
    logic [15:0] r_width;
    logic [15:0] r_height;
    logic [31:0] r_count;
    logic [31:0] r_movi;
    logic [31:0] r_largest;
    logic [31:0] r_area;
    logic [31:0] r_usf;
    logic [31:0] r_rate;
    logic [31:0] r_brate;
    logic [DVD_W-1:0] r_dvd;
    logic [31:0] r_rem;
    logic [31:0] r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic [1:0]  r_sel;
    logic [5:0]  r_pos;
    logic        r_m_valid;
    logic [39:0] r_m_data;
    logic [1:0]  r_m_user;
    logic        r_m_last;

    logic        in_acc;
    logic        advance;
    logic [33:0] trial;
    logic        qbit;
    logic [DVD_W-1:0] n_dvd;
    logic [31:0] n_rem;
    logic [31:0] quot;
    logic [31:0] n_usf;
    logic [24:0] padded;
    logic [5:0]  hoff;
    logic [31:0] idx;
    logic [31:0] area3;
    logic [31:0] hword;
    logic [1:0]  g_dest;
    logic [5:0]  g_off;
    logic [31:0] g_word;
    logic        g_pad;
    logic        g_last;

    // times 1000 as 1024 - 16 - 8
    function automatic logic [DVD_W-1:0] times_1000(input logic [31:0] v);
        return {v, 10'd0} - {6'd0, v, 4'd0} - {7'd0, v, 3'd0};
    endfunction

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign advance       = !r_m_valid || m_axis_tready;

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;
    assign m_axis_tlast  = r_m_last;

    // restoring divider step
    assign trial = {1'b0, r_rem, r_dvd[DVD_W-1]} - {2'b00, r_dvs};
    assign qbit  = !trial[33];
    assign n_rem = qbit ? trial[31:0] : {r_rem[30:0], r_dvd[DVD_W-1]};
    assign n_dvd = {r_dvd[DVD_W-2:0], qbit};
    assign quot  = n_dvd[31:0];
    assign n_usf = (r_count > 32'd1) ? quot : DEFAULT_USF;

    assign padded = {1'b0, r_len} + 25'd1;

    always_comb begin
        hoff  = (r_act == ACT_CLOSE) ? r_pos - 6'(CLOSE_PRE) : r_pos;
        idx   = {r_count[27:0], 4'b0000};
        area3 = r_area + {r_area[30:0], 1'b0};
        case (hoff)
            6'd0:  hword = FCC_RIFF;
            6'd1:  hword = 32'd216 + r_movi + ((idx != 32'd0) ? idx + 32'd8 : 32'd0);
            6'd2:  hword = FCC_AVI;
            6'd3:  hword = FCC_LIST;
            6'd4:  hword = 32'd192;
            6'd5:  hword = FCC_HDRL;
            6'd6:  hword = FCC_AVIH;
            6'd7:  hword = 32'd56;
            6'd8:  hword = r_usf;
            6'd9:  hword = r_brate;
            6'd11: hword = 32'h10;
            6'd12: hword = r_count;
            6'd14: hword = 32'd1;
            6'd15: hword = r_largest + 32'd8;
            6'd16: hword = {16'd0, r_width};
            6'd17: hword = {16'd0, r_height};
            6'd22: hword = FCC_LIST;
            6'd23: hword = 32'd116;
            6'd24: hword = FCC_STRL;
            6'd25: hword = FCC_STRH;
            6'd26: hword = 32'd56;
            6'd27: hword = FCC_VIDS;
            6'd28: hword = FCC_MJPG;
            6'd32: hword = 32'd1000;
            6'd33: hword = r_rate;
            6'd35: hword = r_count;
            6'd36: hword = r_largest + 32'd8;
            6'd37: hword = 32'hFFFF_FFFF;
            6'd40: hword = {r_height, r_width};
            6'd41: hword = FCC_STRF;
            6'd42: hword = 32'd40;
            6'd43: hword = 32'd40;
            6'd44: hword = {16'd0, r_width};
            6'd45: hword = {16'd0, r_height};
            6'd46: hword = PLANES_BITS;
            6'd47: hword = FCC_MJPG;
            6'd48: hword = area3;
            6'd53: hword = FCC_LIST;
            6'd54: hword = 32'd4 + r_movi;
            6'd55: hword = FCC_MOVI;
            default: hword = 32'd0;
        endcase
    end

    always_comb begin
        g_dest = DEST_HEADER;
        g_off  = hoff;
        g_word = hword;
        g_pad  = 1'b0;
        g_last = 1'b0;
        case (r_act)
            ACT_FRAME: begin
                g_dest = DEST_INDEX;
                g_off  = 6'd0;
                g_last = (r_pos == LAST_FRAME);
                case (r_pos)
                    6'd0: begin
                        g_dest = DEST_MOVI;
                        g_word = FCC_00DC;
                    end
                    6'd1: begin
                        g_dest = DEST_MOVI;
                        g_word = {8'd0, r_len};
                        g_pad  = r_len[0];
                    end
                    6'd2: g_word = FCC_00DC;
                    6'd3: g_word = 32'h10;
                    6'd4: g_word = r_movi + 32'd4;
                    default: g_word = {8'd0, r_len};
                endcase
            end
            ACT_CLOSE: begin
                g_last = (r_pos == LAST_CLOSE);
                if (r_pos < 6'(CLOSE_PRE)) begin
                    g_dest = DEST_MOVI;
                    g_off  = 6'd0;
                    g_word = (r_pos == 6'd0) ? FCC_IDX1 : idx;
                end
            end
            default: g_last = (r_pos == LAST_OPEN);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_width   <= 16'd0;
            r_height  <= 16'd0;
            r_count   <= 32'd0;
            r_movi    <= 32'd0;
            r_largest <= 32'd0;
            r_pos     <= 6'd0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_WIDTH:  r_width  <= i_cfg_data;
                    CFG_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_EMIT && advance) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_act <= s_axis_tuser;
                        r_len <= s_axis_tdata[23:0];
                        r_dur <= s_axis_tdata[55:24];
                        r_pos <= 6'd0;
                        unique case (s_axis_tuser)
                            ACT_OPEN: begin
                                r_count   <= 32'd0;
                                r_movi    <= 32'd0;
                                r_largest <= 32'd0;
                                r_usf     <= DEFAULT_USF;
                                r_rate    <= DEFAULT_RATE;
                                r_brate   <= 32'd0;
                                r_state   <= S_PREP;
                            end
                            ACT_FRAME: r_state <= S_EMIT;
                            ACT_CLOSE: r_state <= S_PREP;
                            default: ;
                        endcase
                    end
                end
                S_PREP: begin
                    r_area <= 32'(r_width) * 32'(r_height);
                    if (r_act == ACT_CLOSE) begin
                        r_dvd   <= times_1000(r_dur);
                        r_dvs   <= r_count;
                        r_rem   <= 32'd0;
                        r_cnt   <= '0;
                        r_sel   <= DIV_USF;
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_DIV: begin
                    if (r_cnt == CNT_LAST) begin
                        r_rem <= 32'd0;
                        r_cnt <= '0;
                        unique case (r_sel)
                            DIV_USF: begin
                                r_usf <= n_usf;
                                r_dvd <= RATE_DVD;
                                r_dvs <= n_usf;
                                r_sel <= DIV_RATE;
                            end
                            DIV_RATE: begin
                                r_rate <= (r_usf != 32'd0) ? quot : DEFAULT_RATE;
                                r_dvd  <= times_1000(r_movi);
                                r_dvs  <= r_dur;
                                r_sel  <= DIV_BRATE;
                            end
                            default: begin
                                r_brate <= (r_dur != 32'd0) ? quot : 32'd0;
                                r_state <= S_EMIT;
                            end
                        endcase
                    end else begin
                        r_dvd <= n_dvd;
                        r_rem <= n_rem;
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                S_EMIT: begin
                    if (advance) begin
                        r_m_data  <= {1'b0, g_pad, g_word, g_off};
                        r_m_user  <= g_dest;
                        r_m_last  <= g_last;
                        r_pos     <= r_pos + 6'd1;
                        if (g_last) begin
                            r_state <= S_IDLE;
                            if (r_act == ACT_FRAME) begin
                                r_count <= r_count + 32'd1;
                                r_movi  <= r_movi + 32'd8 + {7'd0, padded[24:1], 1'b0};
                                if ({7'd0, padded[24:1], 1'b0} > r_largest) begin
                                    r_largest <= {7'd0, padded[24:1], 1'b0};
                                end
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/core/avimux_checker.sv]
`default_nettype none
`include "assert_macros.svh"

module avimux_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    import avimux_pkg::*;

    logic in_work;
    logic out_stall;

    assign in_work   = s_axis_tvalid && s_axis_tready &&
                       (s_axis_tuser == ACT_OPEN || s_axis_tuser == ACT_FRAME ||
                        s_axis_tuser == ACT_CLOSE);
    assign out_stall = m_axis_tvalid && !m_axis_tready;

    // a started item holds off the next one
    `ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, in_work, !s_axis_tready)
    // a stalled beat keeps its payload
    `ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, out_stall,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    // pad flag only on movi words
    `ASSERT_IMP(a_pad_movi, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[38],
        m_axis_tuser == DEST_MOVI)
    // offset only on header words
    `ASSERT_IMP(a_off_header, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tuser != DEST_HEADER, m_axis_tdata[5:0] == 6'd0)

endmodule

bind avi_mjpeg_chunk_muxer avimux_checker u_avimux_checker (.*);

`default_nettype wire
